@@ sv/hg_pkg.sv @@
// ----------------------------------------------------------------------------
// hg_pkg: shared types and constants of the harmonic grouper
// Field widths, register map, request codes and the structs that pass
// between the sequencer, the divider and the match evaluator.
// ----------------------------------------------------------------------------
package hg_pkg;

	localparam int MAX_FUND_DEF = 16;

	localparam int FREQ_W  = 24;
	localparam int THR_W   = 16;
	localparam int IDX_W   = 8;
	localparam int FRAC_W  = 16;
	localparam int RATIO_W = FREQ_W + FRAC_W;

	localparam logic [THR_W-1:0] THR_RESET = 16'd655;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Word index of a register, taken from paddr above the byte offset.
	localparam logic [APB_AW-3:0] REG_THRESHOLD = 1'b0;

	localparam logic REQ_CLEAR    = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;

	typedef struct packed {
		logic              start;
		logic [FREQ_W-1:0] dividend;
		logic [FREQ_W-1:0] divisor;
	} hg_div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [RATIO_W-1:0] quotient;
	} hg_div_rsp_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} hg_match_t;

endpackage

@@ sv/hg_if.sv @@
// ----------------------------------------------------------------------------
// hg_in_if / hg_out_if: request and result channels of the harmonic grouper
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface hg_in_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [hg_pkg::FREQ_W-1:0] frequency;

	modport source (output valid, output req_type, output frequency, input ready);
	modport sink (input valid, input req_type, input frequency, output ready);
endinterface

interface hg_out_if;
	logic                     valid;
	logic                     ready;
	logic [hg_pkg::IDX_W-1:0] harmonic_index;
	logic                     new_fundamental;
	logic                     table_dropped;

	modport source (output valid, output harmonic_index, output new_fundamental,
		output table_dropped, input ready);
	modport sink (input valid, input harmonic_index, input new_fundamental,
		input table_dropped, output ready);
endinterface

@@ sv/hg_divider.sv @@
// ----------------------------------------------------------------------------
// hg_divider: iterative restoring divider
// Computes (dividend << FRAC_W) / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hg_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  hg_pkg::hg_div_req_t req,
	output hg_pkg::hg_div_rsp_t rsp
);
	import hg_pkg::*;

	localparam int STEPS = RATIO_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FREQ_W-1:0]  rem_q;
	logic [RATIO_W-1:0] quo_q;
	logic [FREQ_W-1:0]  dvs_q;

	logic [FREQ_W:0]    rem_sh;
	logic               ge;
	logic [FREQ_W:0]    diff;

	// The remainder stays below the divisor, so the shifted value fits FREQ_W+1 bits.
	assign rem_sh = {rem_q, quo_q[RATIO_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= {req.dividend, {FRAC_W{1'b0}}};
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ sv/hg_match.sv @@
// ----------------------------------------------------------------------------
// hg_match: ratio rounding and match test
// Rounds a fixed-point ratio half up, checks the rounding error against the
// threshold and forms the saturated harmonic index.
// ----------------------------------------------------------------------------
module hg_match (
	input  logic [hg_pkg::RATIO_W-1:0] ratio,
	input  logic [hg_pkg::THR_W-1:0]   threshold,
	output hg_pkg::hg_match_t          result
);
	import hg_pkg::*;

	localparam int K_W = RATIO_W - FRAC_W + 1;

	logic [K_W-1:0]    k;
	logic [K_W-1:0]    k_m1;
	logic [FRAC_W:0]   err;
	logic [FRAC_W:0]   frac;

	assign frac = {1'b0, ratio[FRAC_W-1:0]};
	assign k    = {1'b0, ratio[RATIO_W-1:FRAC_W]} + K_W'(ratio[FRAC_W-1]);
	assign k_m1 = k - K_W'(1);

	// Rounded up: the error is the distance to the next integer.
	assign err = ratio[FRAC_W-1] ? ((FRAC_W+1)'(1) << FRAC_W) - frac : frac;

	assign result.hit   = (k != '0) && ((err == '0) || (err < {1'b0, threshold}));
	assign result.index = (k_m1[K_W-1:IDX_W] != '0) ? {IDX_W{1'b1}} : k_m1[IDX_W-1:0];

endmodule

@@ sv/harmonic_grouper_core.sv @@
// ----------------------------------------------------------------------------
// harmonic_grouper_core: groups detected frequencies by harmonic relation
// A clear request empties the table and gives no result. A classify request
// scans the entries in order until a match: store read, check, divider run
// and evaluation per entry, or only read and check for an entry holding zero;
// its result is registered once the output is free. One request at a time,
// the next taken the cycle after the result is registered. Reset empties the
// table and sets the threshold to 655.
// ----------------------------------------------------------------------------
module harmonic_grouper_core #(
	parameter int MAX_FUNDAMENTALS = hg_pkg::MAX_FUND_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	hg_in_if.sink                     item,
	hg_out_if.source                  result,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hg_pkg::APB_AW-1:0] paddr,
	input  logic [hg_pkg::APB_DW-1:0] pwdata,
	output logic [hg_pkg::APB_DW-1:0] prdata,
	output logic                      pready
);
	import hg_pkg::*;

	localparam int CW = $clog2(MAX_FUNDAMENTALS + 1);
	localparam int AW = (MAX_FUNDAMENTALS > 1) ? $clog2(MAX_FUNDAMENTALS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_DIV,
		S_EVAL,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [FREQ_W-1:0] freq_q;
	logic [THR_W-1:0]  thr_q;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              res_valid_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_new_q;
	logic              res_drop_q;
	logic [FREQ_W-1:0] rdata_q;
	logic [FREQ_W-1:0] mem [MAX_FUNDAMENTALS];

	hg_div_req_t       div_req;
	hg_div_rsp_t       div_rsp;
	hg_match_t         match;

	logic              last_entry;
	logic              out_free;
	logic              has_room;
	logic              store_we;
	logic              cfg_we;

	assign last_entry = (CW'(idx_q) + CW'(1)) == count_q;
	assign out_free   = !res_valid_q || result.ready;
	assign has_room   = count_q < CW'(MAX_FUNDAMENTALS);
	assign store_we   = (state_q == S_FINISH) && out_free && !hit_q && has_room;

	// A stored zero never matches, so it skips the divider.
	assign div_req.start    = (state_q == S_CHECK) && (rdata_q != '0);
	assign div_req.dividend = freq_q;
	assign div_req.divisor  = rdata_q;

	hg_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	hg_match u_match (
		.ratio     (div_rsp.quotient),
		.threshold (thr_q),
		.result    (match)
	);

	assign cfg_we = psel && penable && pwrite && pready
		&& (paddr[APB_AW-1:2] == REG_THRESHOLD);
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_THRESHOLD) ? APB_DW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			mem[count_q[AW-1:0]] <= freq_q;
		end
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			freq_q      <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			res_valid_q <= 1'b0;
			res_idx_q   <= '0;
			res_new_q   <= 1'b0;
			res_drop_q  <= 1'b0;
		end else begin
			if (res_valid_q && result.ready && (state_q != S_FINISH)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						if (item.req_type == REQ_CLEAR) begin
							count_q <= '0;
						end else begin
							freq_q  <= item.frequency;
							idx_q   <= '0;
							hit_q   <= 1'b0;
							state_q <= (count_q == '0) ? S_FINISH : S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (rdata_q != '0) begin
						state_q <= S_DIV;
					end else if (last_entry) begin
						state_q <= S_FINISH;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (match.hit) begin
						hit_q     <= 1'b1;
						hit_idx_q <= match.index;
						state_q   <= S_FINISH;
					end else if (last_entry) begin
						state_q <= S_FINISH;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_READ;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_idx_q   <= hit_q ? hit_idx_q : '0;
						res_new_q   <= !hit_q;
						res_drop_q  <= !hit_q && !has_room;
						if (store_we) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item.ready             = (state_q == S_IDLE);
	assign result.valid           = res_valid_q;
	assign result.harmonic_index  = res_idx_q;
	assign result.new_fundamental = res_new_q;
	assign result.table_dropped   = res_drop_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FUNDAMENTALS))
		else $error("entry count exceeds table depth");

	a_drop_is_new: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!result.table_dropped || result.new_fundamental))
		else $error("dropped result not marked as new fundamental");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.req_type == REQ_CLEAR) |=> (count_q == '0))
		else $error("clear request did not empty the table");

	a_store_counts: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |=> (count_q == $past(count_q) + CW'(1)))
		else $error("store write without count increment");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

endmodule
